/* hdl/bffa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_pkg
// types and fixed codes for the first-fit bitmap block allocator
// ----------------------------------------------------------------------------
package bffa_pkg;

  // operation codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_REJECT  = 2'd2;

  // register word indexes on the configuration port
  localparam logic REG_HEAP_BASE = 1'b0;

  localparam logic [31:0] HEAP_BASE_RESET = 32'h2000_1000;

  typedef struct packed {
    logic        func;
    logic [15:0] request_bytes;
    logic [31:0] release_address;
  } req_t;

  typedef struct packed {
    logic [31:0] granted_address;
    logic [1:0]  status;
  } rsp_t;

endpackage

/* hdl/bitmap_first_fit_block_allocator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_first_fit_block_allocator_unit
// fixed-block heap allocator: first-fit search over a used/free bitmap
// ----------------------------------------------------------------------------
// rejects: zero size or address outside the heap in the idle state, oversize or off boundary after the divide
// throughput: one item at a time, busy high until the strobe (never for a reject in idle), next item taken then
// done is high for exactly one cycle with the result on rsp; it cannot be held
// reset: a clearing pass over all NUM_BLOCKS blocks after rst falls, busy high throughout
module bitmap_first_fit_block_allocator_unit
  import bffa_pkg::*;
#(
  parameter int NUM_BLOCKS      = 256,
  parameter int BYTES_PER_BLOCK = 16
) (
  input  logic        clk,
  input  logic        rst,
  // command side
  input  logic        start,
  output logic        busy,
  input  req_t        req,
  output logic        done,
  output rsp_t        rsp,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // block index width and a counter one bit wider so it can reach NUM_BLOCKS
  localparam int IDXW = $clog2(NUM_BLOCKS);
  localparam int SPAN = NUM_BLOCKS * BYTES_PER_BLOCK;
  // byte offset inside the heap
  localparam int OFFW = $clog2(SPAN);
  // dividend/quotient width covers both a rounded size and an offset
  localparam int DW   = (OFFW > 17) ? OFFW : 17;
  // reciprocal for an exact divide of any DW-bit value by the block size
  localparam int LOGB = $clog2(BYTES_PER_BLOCK);
  localparam int RSH  = DW + LOGB;
  localparam int MW   = DW + 2;
  localparam logic [MW-1:0] DIV_MUL =
    MW'(((64'd1 << RSH) + 64'(BYTES_PER_BLOCK - 1)) / 64'(BYTES_PER_BLOCK));

  localparam logic [IDXW:0]  NUM_CNT  = (IDXW + 1)'(NUM_BLOCKS);
  localparam logic [IDXW:0]  LAST_CNT = (IDXW + 1)'(NUM_BLOCKS - 1);
  localparam logic [DW-1:0]  NUM_Q    = DW'(NUM_BLOCKS);

  // sequencer codes
  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_MARK = 3'd5;
  localparam logic [2:0] S_FREE = 3'd6;

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  logic [2:0]      state, state_next;
  logic [31:0]     heap_base;
  logic            op, op_next;
  logic [IDXW:0]   addr, addr_next;          // walk / sweep pointer
  logic            chk_valid, chk_valid_next; // read data in flight
  logic [IDXW-1:0] chk_idx, chk_idx_next;     // block whose bit is in rd_data
  logic [IDXW:0]   need, need_next;          // blocks wanted
  logic [IDXW:0]   run_len, run_len_next;    // free run length / mark count
  logic [IDXW-1:0] run_start, run_start_next;
  logic [DW-1:0]   dvd, dvd_next;
  logic [DW-1:0]   quo, quo_next;
  logic            done_next;
  rsp_t            rsp_next;

  // bitmap memory, one bit per block, registered read
  logic            map_mem [NUM_BLOCKS];
  logic            mem_we;
  logic [IDXW-1:0] mem_waddr;
  logic            mem_wdata;
  logic            mem_re;
  logic            rd_data;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_HEAP_BASE) ? heap_base : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= HEAP_BASE_RESET;
    end else if (cfg_wr && paddr[2] == REG_HEAP_BASE) begin
      heap_base <= pwdata;
    end
  end

  // --------------------------------------------------------------------------
  // divide by the block size: reciprocal multiply, then a multiply back to
  // tell whether anything was left over
  // --------------------------------------------------------------------------
  logic [DW+MW-1:0] div_prod;
  logic [DW-1:0]    quo_back;

  assign div_prod = (DW + MW)'(dvd) * (DW + MW)'(DIV_MUL);
  assign quo_back = quo * DW'(BYTES_PER_BLOCK);

  // --------------------------------------------------------------------------
  // free request range check, on unwrapped 33-bit values
  // --------------------------------------------------------------------------
  logic [32:0] rel33, base33, limit33;
  logic        rel_out;
  logic [31:0] rel_off;

  assign rel33   = {1'b0, req.release_address};
  assign base33  = {1'b0, heap_base};
  assign limit33 = base33 + 33'(SPAN);
  assign rel_out = (rel33 < base33) || (rel33 >= limit33);
  assign rel_off = req.release_address - heap_base;

  // run bookkeeping while scanning
  logic [IDXW:0]   run_inc;
  logic [IDXW-1:0] run_base;

  assign run_inc  = run_len + 1'b1;
  assign run_base = (run_len == '0) ? chk_idx : run_start;

  assign busy = (state != S_IDLE);

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_next     = state;
    op_next        = op;
    addr_next      = addr;
    chk_valid_next = 1'b0;
    chk_idx_next   = addr[IDXW-1:0];
    need_next      = need;
    run_len_next   = run_len;
    run_start_next = run_start;
    dvd_next       = dvd;
    quo_next       = quo;
    done_next      = 1'b0;
    rsp_next       = rsp;
    mem_we         = 1'b0;
    mem_waddr      = addr[IDXW-1:0];
    mem_wdata      = 1'b0;
    mem_re         = 1'b0;

    unique case (state)
      S_INIT: begin
        // clearing pass, every block free
        mem_we    = 1'b1;
        mem_wdata = 1'b0;
        addr_next = addr + 1'b1;
        if (addr == LAST_CNT) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          op_next  = req.func;
          quo_next = '0;
          if (req.func == FUNC_ALLOC) begin
            if (req.request_bytes == 16'd0) begin
              done_next = 1'b1;
              rsp_next  = '{granted_address: 32'd0, status: ST_REJECT};
            end else begin
              // round up to whole blocks
              dvd_next   = DW'({1'b0, req.request_bytes} + 17'(BYTES_PER_BLOCK - 1));
              state_next = S_DIV;
            end
          end else begin
            if (rel_out) begin
              done_next = 1'b1;
              rsp_next  = '{granted_address: 32'd0, status: ST_REJECT};
            end else begin
              dvd_next   = DW'(rel_off[OFFW-1:0]);
              state_next = S_DIV;
            end
          end
        end
      end

      S_DIV: begin
        quo_next   = DW'(div_prod >> RSH);
        state_next = S_EVAL;
      end

      S_EVAL: begin
        addr_next    = '0;
        run_len_next = '0;
        if (op == FUNC_ALLOC) begin
          if (quo > NUM_Q) begin
            state_next = S_IDLE;
            done_next  = 1'b1;
            rsp_next   = '{granted_address: 32'd0, status: ST_REJECT};
          end else begin
            need_next  = quo[IDXW:0];
            state_next = S_SCAN;
          end
        end else begin
          if (dvd != quo_back) begin
            // off block boundary
            state_next = S_IDLE;
            done_next  = 1'b1;
            rsp_next   = '{granted_address: 32'd0, status: ST_REJECT};
          end else begin
            addr_next  = {1'b0, quo[IDXW-1:0]};
            state_next = S_FREE;
          end
        end
      end

      S_SCAN: begin
        // issue the next read while the previous bit is checked
        if (addr != NUM_CNT) begin
          mem_re         = 1'b1;
          chk_valid_next = 1'b1;
          addr_next      = addr + 1'b1;
        end
        if (chk_valid) begin
          if (!rd_data) begin
            run_start_next = run_base;
            if (run_inc == need) begin
              chk_valid_next = 1'b0;
              addr_next      = {1'b0, run_base};
              run_len_next   = '0;
              state_next     = S_MARK;
            end else begin
              run_len_next = run_inc;
            end
          end else begin
            run_len_next = '0;
          end
        end else if (addr == NUM_CNT) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
          rsp_next   = '{granted_address: 32'd0, status: ST_NOSPACE};
        end
      end

      S_MARK: begin
        mem_we       = 1'b1;
        mem_wdata    = 1'b1;
        addr_next    = addr + 1'b1;
        run_len_next = run_inc;
        if (run_inc == need) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
          rsp_next.granted_address = heap_base +
                                     (32'(run_start) * 32'(BYTES_PER_BLOCK));
          rsp_next.status = ST_DONE;
        end
      end

      S_FREE: begin
        // release consecutive used blocks until a free one or the heap end
        if (addr != NUM_CNT) begin
          mem_re         = 1'b1;
          chk_valid_next = 1'b1;
          addr_next      = addr + 1'b1;
        end
        if (chk_valid) begin
          if (rd_data) begin
            mem_we    = 1'b1;
            mem_waddr = chk_idx;
            mem_wdata = 1'b0;
          end else begin
            chk_valid_next = 1'b0;
            state_next     = S_IDLE;
            done_next      = 1'b1;
            rsp_next       = '{granted_address: 32'd0, status: ST_DONE};
          end
        end else if (addr == NUM_CNT) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
          rsp_next   = '{granted_address: 32'd0, status: ST_DONE};
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      addr      <= '0;
      chk_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      addr      <= addr_next;
      chk_valid <= chk_valid_next;
      done      <= done_next;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    op        <= op_next;
    chk_idx   <= chk_idx_next;
    need      <= need_next;
    run_len   <= run_len_next;
    run_start <= run_start_next;
    dvd       <= dvd_next;
    quo       <= quo_next;
    rsp       <= rsp_next;
  end

  // bitmap store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= map_mem[addr[IDXW-1:0]];
    end
  end

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  // result strobe only ever comes with the sequencer back at rest
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // a failed request never carries an address
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != ST_DONE) |-> (rsp.granted_address == 32'd0))
    else $error("failed request with nonzero address");

  // marking never runs past the requested block count
  a_mark_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_MARK) |-> (run_len < need))
    else $error("mark overran run");

  // a read is only issued inside the heap
  a_read_range: assert property (@(posedge clk) disable iff (rst)
    mem_re |-> (addr < NUM_CNT))
    else $error("bitmap read beyond heap");

endmodule

/* bench/bffa_heap_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_heap_checker
// watches the command and configuration ports of the block allocator,
// predicts each result from its own copy of the block map and heap base,
// and compares every result strobe against the oldest prediction
// ----------------------------------------------------------------------------
module bffa_heap_checker
  import bffa_pkg::*;
#(
  parameter int NUM_BLOCKS      = 256,
  parameter int BYTES_PER_BLOCK = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  req_t        req,
  input  logic        done,
  input  rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          items_taken,
  output int          results_seen,
  output int          n_granted,
  output int          n_full,
  output int          n_rejected,
  output int          n_freed
);

  localparam logic [2:0] HEAP_BASE_ADDR = {REG_HEAP_BASE, 2'b00};

  logic [NUM_BLOCKS-1:0] used_map;
  logic [31:0]           base_addr;
  rsp_t                  pending_outcomes[$];

  // first-fit allocate or run release on the local map
  function automatic rsp_t first_fit_outcome(req_t r);
    rsp_t            o;
    int unsigned     need;
    int unsigned     run;
    int              first;
    int              idx;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned a;
    o.granted_address = '0;
    o.status          = ST_DONE;
    if (r.func == FUNC_ALLOC) begin
      need = (r.request_bytes + BYTES_PER_BLOCK - 1) / BYTES_PER_BLOCK;
      if (r.request_bytes == 0 || need > NUM_BLOCKS) begin
        o.status = ST_REJECT;
      end else begin
        first = -1;
        run   = 0;
        for (int b = 0; b < NUM_BLOCKS && first < 0; b++) begin
          run = used_map[b] ? 0 : run + 1;
          if (run == need) first = b - int'(need) + 1;
        end
        if (first < 0) begin
          o.status = ST_NOSPACE;
        end else begin
          for (int b = first; b < first + int'(need); b++) used_map[b] = 1'b1;
          o.granted_address = base_addr + 32'(first * BYTES_PER_BLOCK);
        end
      end
    end else begin
      a  = r.release_address;
      lo = base_addr;
      hi = lo + NUM_BLOCKS * BYTES_PER_BLOCK;
      if (a < lo || a >= hi || (a - lo) % BYTES_PER_BLOCK != 0) begin
        o.status = ST_REJECT;
      end else begin
        idx = int'((a - lo) / BYTES_PER_BLOCK);
        while (idx < NUM_BLOCKS && used_map[idx]) begin
          used_map[idx] = 1'b0;
          idx++;
        end
      end
    end
    return o;
  endfunction

  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      used_map  = '0;
      base_addr = HEAP_BASE_RESET;
      pending_outcomes.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == HEAP_BASE_ADDR)
        base_addr = pwdata;
      if (done) begin
        results_seen++;
        if (pending_outcomes.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, got addr %h status %0d",
                   $time, rsp.granted_address, rsp.status);
        end else begin
          want = pending_outcomes.pop_front();
          if (rsp.granted_address !== want.granted_address) begin
            errors++;
            $display("%0t: granted_address expected %h, got %h",
                     $time, want.granted_address, rsp.granted_address);
          end
          if (rsp.status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d, got %0d", $time, want.status, rsp.status);
          end
        end
      end
      if (start && !busy) begin
        want = first_fit_outcome(req);
        pending_outcomes.push_back(want);
        items_taken++;
        case (want.status)
          ST_DONE:    if (req.func == FUNC_ALLOC) n_granted++; else n_freed++;
          ST_NOSPACE: n_full++;
          default:    n_rejected++;
        endcase
      end
    end
  end

endmodule

/* bench/bitmap_first_fit_block_allocator_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_first_fit_block_allocator_unit_tb
// drives allocate and free items into the block allocator over several heap
// base settings and sender idle rates; a separate checker predicts and
// compares every result, and this module gives the verdict
// ----------------------------------------------------------------------------
module bitmap_first_fit_block_allocator_unit_tb;
  import bffa_pkg::*;

  localparam int NUM_BLOCKS       = 256;
  localparam int BYTES_PER_BLOCK  = 16;
  localparam int HEAP_SPAN        = NUM_BLOCKS * BYTES_PER_BLOCK;
  localparam int RANDOM_PER_PHASE = 92;
  localparam int STALL_LIMIT      = 4000;
  localparam int DRAIN_CYCLES     = 600;
  localparam int LIVE_MAX         = 64;
  localparam logic [2:0] HEAP_BASE_ADDR = {REG_HEAP_BASE, 2'b00};
  // word index 1 has no register behind it
  localparam logic [2:0] SPARE_REG_ADDR = 3'd4;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  req_t        req;
  logic        done;
  rsp_t        rsp;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int errors;
  int items_taken;
  int results_seen;
  int n_granted;
  int n_full;
  int n_rejected;
  int n_freed;

  int          idle_pct;
  int          stall_cycles;
  logic        sent_func;
  logic [31:0] live_grants[$];

  bitmap_first_fit_block_allocator_unit #(
    .NUM_BLOCKS      (NUM_BLOCKS),
    .BYTES_PER_BLOCK (BYTES_PER_BLOCK)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .req     (req),
    .done    (done),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bffa_heap_checker #(
    .NUM_BLOCKS      (NUM_BLOCKS),
    .BYTES_PER_BLOCK (BYTES_PER_BLOCK)
  ) checker_i (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .done         (done),
    .rsp          (rsp),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .errors       (errors),
    .items_taken  (items_taken),
    .results_seen (results_seen),
    .n_granted    (n_granted),
    .n_full       (n_full),
    .n_rejected   (n_rejected),
    .n_freed      (n_freed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: cycles with no item taken and no result strobe
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("bitmap_first_fit_block_allocator_unit_tb: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // remember granted runs so that most frees name a real allocation
  // sent_func is updated by nba at the taking edge, so here it still
  // belongs to the item whose result is on rsp
  always @(posedge clk) begin
    if (!rst && done && sent_func == FUNC_ALLOC && rsp.status == ST_DONE &&
        live_grants.size() < LIVE_MAX) begin
      live_grants.push_back(rsp.granted_address);
    end
  end

  // apb write: setup cycle, access cycle, then back to an idle bus
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // present one item and return at the edge that takes it; start is left
  // high so a following item can go straight in once busy falls
  task automatic issue(input logic f, input logic [15:0] n, input logic [31:0] a);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req   <= {f, n, a};
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    sent_func <= f;
  endtask

  // drop start and wait until every predicted result has been seen
  task automatic settle;
    start <= 1'b0;
    @(negedge clk);
    while (items_taken != results_seen) @(negedge clk);
    @(posedge clk);
  endtask

  // one heap base setting with random traffic: mostly sensible allocates
  // and frees of live runs, some oversize requests and malformed frees
  task automatic run_phase(input logic [31:0] base, input int pct);
    int          choice;
    int          pick;
    logic [15:0] n;
    logic [31:0] a;
    settle;
    write_reg(HEAP_BASE_ADDR, base);
    live_grants.delete();
    idle_pct = pct;
    repeat (RANDOM_PER_PHASE) begin
      choice = $urandom_range(99);
      pick   = $urandom_range(19);
      n      = 16'($urandom);
      a      = $urandom;
      if (choice < 50) begin
        // small sizes fill the map in many fragments
        if (pick < 15)       n = 16'($urandom_range(64, 1));
        else if (pick < 17)  n = 16'($urandom_range(HEAP_SPAN, 65));
        else if (pick == 17) n = 16'(HEAP_SPAN - $urandom_range(BYTES_PER_BLOCK, 0));
        else if (pick == 18) n = 16'(HEAP_SPAN + $urandom_range(BYTES_PER_BLOCK, 1));
        issue(FUNC_ALLOC, n, a);
      end else if (choice < 88) begin
        if (live_grants.size() != 0 && pick < 15) begin
          pick = $urandom_range(live_grants.size() - 1);
          a    = live_grants[pick];
          live_grants.delete(pick);
        end else begin
          a = base + 32'(BYTES_PER_BLOCK * $urandom_range(NUM_BLOCKS - 1));
        end
        issue(FUNC_FREE, n, a);
      end else begin
        // off a block boundary, just below base, at or past the heap end, or a random address
        case (pick % 4)
          0: a = base + 32'(BYTES_PER_BLOCK * $urandom_range(NUM_BLOCKS - 1)) +
                 32'($urandom_range(BYTES_PER_BLOCK - 1, 1));
          1: a = base - 32'($urandom_range(BYTES_PER_BLOCK, 1));
          2: a = base + 32'(HEAP_SPAN + $urandom_range(BYTES_PER_BLOCK, 0));
          default: ;
        endcase
        issue(FUNC_FREE, n, a);
      end
    end
  endtask

  initial begin
    logic [31:0] hb;
    rst       = 1'b1;
    start     = 1'b0;
    req       = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    sent_func = FUNC_ALLOC;
    idle_pct  = 37;
    hb        = HEAP_BASE_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // the clearing pass keeps busy high for a whole walk of the map
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);

    // unlisted register index must be ignored
    write_reg(SPARE_REG_ADDR, $urandom);
    write_reg(HEAP_BASE_ADDR, hb);

    // directed: size edges, first fit, run release and its spill-over
    issue(FUNC_ALLOC, 16'd0,     $urandom);                      // zero size
    issue(FUNC_ALLOC, 16'd1,     $urandom);                      // block 0
    issue(FUNC_ALLOC, 16'd16,    $urandom);                      // block 1
    issue(FUNC_ALLOC, 16'd17,    $urandom);                      // blocks 2-3
    issue(FUNC_ALLOC, 16'(HEAP_SPAN + 1), $urandom);             // one block too many
    issue(FUNC_ALLOC, 16'hFFFF,  $urandom);                      // largest size
    issue(FUNC_FREE,  16'($urandom), hb + 32'd16);               // also frees blocks 2-3
    issue(FUNC_FREE,  16'($urandom), hb + 32'd16);               // already free
    issue(FUNC_FREE,  16'($urandom), hb - 32'd1);                // just below base
    issue(FUNC_FREE,  16'($urandom), hb + 32'(HEAP_SPAN));       // just past the end
    issue(FUNC_FREE,  16'($urandom), hb + 32'(HEAP_SPAN - 1));   // last byte, off boundary
    issue(FUNC_FREE,  16'($urandom), hb + 32'd8);                // mid block
    issue(FUNC_FREE,  16'($urandom), 32'hFFFF_FFFF);
    issue(FUNC_FREE,  16'($urandom), 32'h0000_0000);
    issue(FUNC_FREE,  16'($urandom), hb);                        // block 0
    issue(FUNC_ALLOC, 16'(HEAP_SPAN), $urandom);                 // whole heap
    issue(FUNC_ALLOC, 16'd1,     $urandom);                      // no space left
    issue(FUNC_FREE,  16'($urandom), hb + 32'(HEAP_SPAN - BYTES_PER_BLOCK)); // last block
    issue(FUNC_ALLOC, 16'd16,    $urandom);                      // lands in last block
    issue(FUNC_FREE,  16'($urandom), hb);                        // run to the heap end
    issue(FUNC_ALLOC, 16'(HEAP_SPAN - BYTES_PER_BLOCK + 1), $urandom); // rounds to whole heap
    issue(FUNC_FREE,  16'($urandom), hb + 32'(HEAP_SPAN / 2));   // upper half
    issue(FUNC_ALLOC, 16'(HEAP_SPAN / 2), $urandom);             // fits upper half exactly
    issue(FUNC_ALLOC, 16'd1,     $urandom);                      // full again
    issue(FUNC_FREE,  16'($urandom), hb);                        // clear everything

    // random traffic over base settings and idle rates
    run_phase(HEAP_BASE_RESET, 37);
    run_phase(32'hFFFF_F800,   37);   // grants wrap past the top of the space
    run_phase(32'h0000_0000,   78);
    run_phase(32'hFFFF_FFFF,   78);
    run_phase($urandom,        0);
    run_phase(32'h7654_3219,   0);

    settle;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d items over six heap bases at sender idle rates of 37, 78 and 0 percent",
             items_taken);
    $display("%0d granted, %0d out of space, %0d rejected, %0d frees done, %0d mismatches",
             n_granted, n_full, n_rejected, n_freed, errors);
    if (errors == 0 && items_taken == results_seen) begin
      $display("bitmap_first_fit_block_allocator_unit_tb: done, clean");
    end else begin
      if (items_taken != results_seen)
        $display("%0t: %0d results never arrived", $time, items_taken - results_seen);
      $display("bitmap_first_fit_block_allocator_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
